// ----- hdl/sitda_pkg.sv -----
package sitda_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned Digits = 10;
  localparam int unsigned BcdW   = 4 * Digits;
  localparam int unsigned CntW   = $clog2(ValueW);
  localparam int unsigned LeftW  = $clog2(Digits + 1);
  localparam int unsigned CharW  = 8;

  localparam logic [CntW-1:0]  LastBit   = CntW'(ValueW - 1);
  localparam logic [LeftW-1:0] AllDigits = LeftW'(Digits);
  localparam logic [LeftW-1:0] OneDigit  = LeftW'(1);

  localparam logic [CharW-1:0] CharZero  = 8'd48;
  localparam logic [CharW-1:0] CharNine  = 8'd57;
  localparam logic [CharW-1:0] CharMinus = 8'd45;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_HOLD
  } sitda_conv_e;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SKIP,
    EMIT_SEND
  } sitda_emit_e;

  // Converted number handed from the converter to the character emitter.
  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
  } sitda_num_t;

endpackage

// ----- hdl/sitda_dabble.sv -----
module sitda_dabble import sitda_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] value_i,
  output logic              ready_o,
  output logic              num_valid_o,
  input  logic              num_ready_i,
  output sitda_num_t        num_o
);

  sitda_conv_e       state_q, state_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic [BcdW-1:0]   adj;
  logic              bcd_ok;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    adj    = bcd_q;
    bcd_ok = 1'b1;
    for (int i = 0; i < Digits; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end
      if (bcd_q[i*4 +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  // Handshake outputs depend on the state alone.
  assign ready_o     = (state_q == CONV_IDLE);
  assign num_valid_o = (state_q == CONV_HOLD);

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    unique case (state_q)
      CONV_IDLE: begin
        if (start_i) begin
          neg_d   = value_i[ValueW-1];
          mag_d   = value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = CONV_RUN;
        end
      end
      CONV_RUN: begin
        bcd_d = {adj[BcdW-2:0], mag_q[ValueW-1]};
        mag_d = {mag_q[ValueW-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastBit) begin
          state_d = CONV_HOLD;
        end
      end
      CONV_HOLD: begin
        if (num_ready_i) begin
          state_d = CONV_IDLE;
        end
      end
      default: state_d = CONV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CONV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

  assign num_o.neg = neg_q;
  assign num_o.bcd = bcd_q;

  a_bcd_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CONV_RUN || state_q == CONV_HOLD) |-> bcd_ok)
    else $error("BCD digit above nine during conversion");

endmodule

// ----- hdl/sitda_emit.sv -----
module sitda_emit import sitda_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             num_valid_i,
  output logic             num_ready_o,
  input  sitda_num_t       num_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] out_char_o,
  output logic             out_last_o
);

  sitda_emit_e      state_q, state_d;
  logic [BcdW-1:0]  dig_q, dig_d;
  logic [LeftW-1:0] left_q, left_d;
  logic             neg_q, neg_d;
  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             slot_free;
  logic [3:0]       top_dig;

  assign slot_free   = !valid_q || out_ready_i;
  assign top_dig     = dig_q[BcdW-1 -: 4];
  assign num_ready_o = (state_q == EMIT_IDLE);

  always_comb begin
    state_d     = state_q;
    dig_d       = dig_q;
    left_d      = left_q;
    neg_d       = neg_q;
    valid_d     = valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    unique case (state_q)
      EMIT_IDLE: begin
        if (num_valid_i) begin
          dig_d   = num_i.bcd;
          neg_d   = num_i.neg;
          left_d  = AllDigits;
          state_d = EMIT_SKIP;
        end
      end
      EMIT_SKIP: begin
        // Drop leading zeros, always keeping the final digit.
        if (top_dig == 4'd0 && left_q != OneDigit) begin
          dig_d  = {dig_q[BcdW-5:0], 4'd0};
          left_d = left_q - LeftW'(1);
        end else begin
          state_d = EMIT_SEND;
        end
      end
      EMIT_SEND: begin
        if (slot_free) begin
          valid_d = 1'b1;
          if (neg_q) begin
            char_d = CharMinus;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = CharZero + CharW'(top_dig);
            last_d = (left_q == OneDigit);
            dig_d  = {dig_q[BcdW-5:0], 4'd0};
            left_d = left_q - LeftW'(1);
            if (left_q == OneDigit) begin
              state_d = EMIT_IDLE;
            end
          end
        end
      end
      default: state_d = EMIT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EMIT_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    left_q <= left_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (char_q == CharMinus) || (char_q >= CharZero && char_q <= CharNine))
    else $error("character outside sign and digit set");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && char_q == CharMinus) |-> !last_q)
    else $error("minus sign flagged as last character");

  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EMIT_SKIP || state_q == EMIT_SEND) |->
      (left_q != '0 && left_q <= AllDigits))
    else $error("digit count out of range while emitting");

endmodule

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// Channel   Dir  Transfer when                  Payload
// s_axis    in   s_axis_tvalid & s_axis_tready  tdata[31:0] value (signed)
// m_axis    out  m_axis_tvalid & m_axis_tready  tdata[7:0] character, tlast last
//
// A value is loaded, converted in the bit-serial double dabble converter, then
// handed over to the emitter. Leading zeros are skipped at one digit a cycle
// (up to nine) and characters leave at most one a cycle through an output
// register. Conversion of the next value overlaps emission of the previous one,
// so the converter can take a new value while the emitter is still sending.
// Reset is asynchronous and active low; it clears both state machines and the
// output valid. A stalled sink holds the emitter, which in turn holds the converter.
module signed_int_to_decimal_ascii import sitda_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ValueW-1:0] s_axis_tdata,   // [31:0] value
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [CharW-1:0]  m_axis_tdata,   // [7:0] character
  output logic              m_axis_tlast    // last character of the number
);

  logic       start;
  logic       num_valid;
  logic       num_ready;
  sitda_num_t num;

  // The converter takes a value only when it is idle; its result waits in its
  // own registers until the emitter has finished the previous number.
  assign start = s_axis_tvalid && s_axis_tready;

  sitda_dabble u_dabble (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .value_i     (s_axis_tdata),
    .ready_o     (s_axis_tready),
    .num_valid_o (num_valid),
    .num_ready_i (num_ready),
    .num_o       (num)
  );

  // The emitter sends the sign, if any, then the significant digits from the
  // most significant one down, flagging the final digit.
  sitda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .num_valid_i (num_valid),
    .num_ready_o (num_ready),
    .num_i       (num),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- tb/signed_int_to_decimal_ascii_checker.sv -----
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_checker import sitda_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [ValueW-1:0] s_axis_tdata,   // [31:0] value
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [CharW-1:0]  m_axis_tdata,   // [7:0] character
  input  logic              m_axis_tlast,
  output int                pending_o,
  output int                fail_count_o
);

  localparam int unsigned Radix     = 10;
  localparam int unsigned MaxDigits = 10;
  // Keeps the log readable when the block is badly broken.
  localparam int unsigned MaxPrinted = 100;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t oldest_char;
  int         mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxPrinted) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Appends the decimal text of one value, most significant character first.
  function automatic void queue_decimal_text(input logic [ValueW-1:0] value);
    logic [ValueW-1:0] magnitude;
    logic [3:0]        digit_buf [MaxDigits];
    int                digit_count;
    text_char_t        next_char;
    // Unsigned negation wraps, so the most negative value keeps its magnitude.
    magnitude   = value[ValueW-1] ? (ValueW'(0) - value) : value;
    digit_count = 0;
    do begin
      digit_buf[digit_count] = 4'(magnitude % Radix);
      magnitude              = magnitude / Radix;
      digit_count++;
    end while (magnitude != 0 && digit_count < MaxDigits);
    if (value[ValueW-1]) begin
      next_char.code = CharMinus;
      next_char.last = 1'b0;
      expected_text.push_back(next_char);
    end
    for (int i = digit_count - 1; i >= 0; i--) begin
      next_char.code = CharZero + CharW'(digit_buf[i]);
      next_char.last = (i == 0);
      expected_text.push_back(next_char);
    end
  endfunction

  // Outputs are handled before inputs so that a character can never be
  // matched against text of a value accepted in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_text.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h last %0b with none expected",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          oldest_char = expected_text.pop_front();
          if (m_axis_tdata !== oldest_char.code) begin
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      m_axis_tdata, oldest_char.code));
          end
          if (m_axis_tlast !== oldest_char.last) begin
            report_mismatch($sformatf("tlast %0b on character 0x%02h, expected %0b",
                                      m_axis_tlast, oldest_char.code, oldest_char.last));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        queue_decimal_text(s_axis_tdata);
      end
      pending_o <= expected_text.size();
    end
  end

endmodule

// ----- tb/signed_int_to_decimal_ascii_tb.sv -----
`timescale 1ns / 100ps

// Top of the testbench. It makes the clock and the reset, feeds values into
// the slave-side stream and pulls characters from the master-side stream with
// random gaps and stalls. All prediction and comparison lives in the checker,
// which hands back the number of characters still owed and a failure count.
module signed_int_to_decimal_ascii_tb;
  import sitda_pkg::*;

  localparam int unsigned RandomItems = 370;
  // Cycles to let pass after the last character, well above the conversion
  // latency of a single value.
  localparam int unsigned DrainCycles = 120;
  // Slowest correct run: about 390 values, each with 11 characters that may
  // each wait out the longest sink stall, plus the longest sender gap and the
  // conversion. That is under 1.2 ms; the limit allows several times that.
  localparam int unsigned LimitNs = 8_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [ValueW-1:0] s_axis_tdata;   // [31:0] value
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [CharW-1:0]  m_axis_tdata;   // [7:0] character
  logic              m_axis_tlast;

  int pending_chars;
  int fail_count;

  // While set, neither side idles, so back-to-back transfers get exercised.
  logic no_idle = 1'b0;

  signed_int_to_decimal_ascii u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  signed_int_to_decimal_ascii_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pending_o     (pending_chars),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Idle length in cycles: mostly none or a few, now and then a long one.
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 60);
  endfunction

  // Offers one value after an optional idle stretch and returns at the rising
  // edge where the transfer takes place. Valid stays high from one value to
  // the next when no idle is wanted, so each step sees one assignment only.
  task automatic send_value(input logic [ValueW-1:0] value);
    int idle;
    idle = pick_idle();
    @(negedge clk_i);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the sender back until the checker owes no more characters.
  task automatic wait_until_drained();
    do @(posedge clk_i); while (pending_chars != 0);
  endtask

  // A random value shaped to reach every digit count and the carry edges:
  // raw 32-bit patterns, values of a chosen digit length, neighbors of the
  // powers of ten, and small values.
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned       kind;
    int unsigned       digit_len;
    int unsigned       low_bound;
    int unsigned       high_bound;
    logic [ValueW-1:0] magnitude;
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        return $urandom();
      end
      1: begin
        digit_len  = $urandom_range(1, 9);
        low_bound  = (digit_len == 1) ? 0 : 10 ** (digit_len - 1);
        high_bound = 10 ** digit_len - 1;
        magnitude  = $urandom_range(high_bound, low_bound);
      end
      2: begin
        magnitude = 10 ** $urandom_range(0, 9);
        magnitude = magnitude + ValueW'($urandom_range(0, 2)) - ValueW'(1);
      end
      default: begin
        magnitude = $urandom_range(0, 20);
      end
    endcase
    return $urandom_range(0, 1) ? (ValueW'(0) - magnitude) : magnitude;
  endfunction

  // Sink side: random stalls, short ones mostly, never while no_idle is set.
  initial begin
    int stall_left;
    int next_ready;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (no_idle) begin
        stall_left = 0;
      end else if (stall_left == 0) begin
        stall_left = pick_idle();
      end
      if (stall_left > 0) begin
        next_ready = 0;
        stall_left--;
      end else begin
        next_ready = 1;
      end
      m_axis_tready <= next_ready[0];
    end
  end

  initial begin
    logic [ValueW-1:0] directed_values [$];
    directed_values = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7FFF_FFFF, 32'h8000_0000, -32'sd2147483647,
      32'd999_999_999, 32'd1_000_000_000, -32'sd999_999_999, -32'sd1_000_000_000,
      32'd12345, -32'sd67890, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'sd7,
      32'd1_000_000_001, 32'd2_000_000_000
    };

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: zero, the sign boundaries, the most negative value, the
    // digit count boundaries 1-2, 2-3 and 9-10, and alternating bit patterns.
    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
    end

    // Let the block empty completely before the random part starts.
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_until_drained();

    for (int n = 0; n < RandomItems; n++) begin
      // Switch between stretches with and without idling now and then.
      if (n % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_value(pick_value());
      // Occasionally stop feeding until every owed character has left.
      if ($urandom_range(0, 49) == 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        wait_until_drained();
      end
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending_chars == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #(LimitNs);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sitda_pkg.sv
hdl/sitda_dabble.sv
hdl/sitda_emit.sv
hdl/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_checker.sv
tb/signed_int_to_decimal_ascii_tb.sv
